FILE: src/itlca_pkg.sv
// ----------------------------------------------------------------------------
// itlca_pkg
// Shared widths, sizes and codes of the incremental tree LCA block.
// ----------------------------------------------------------------------------
package itlca_pkg;
	localparam int MAX_NODES   = 1024;
	localparam int LIFT_LEVELS = 10;

	localparam int NODE_W = 10;
	localparam int DEP_W  = 10;
	localparam int DIST_W = 32;
	localparam int WGT_W  = 16;
	localparam int STAT_W = 2;
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int LVL_W  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int ANC_AW = NODE_W + LVL_W;
	localparam int CMP_W  = LIFT_LEVELS + DEP_W + 1;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [DEP_W-1:0]  dep_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [LVL_W-1:0]  lvl_t;
endpackage

FILE: src/itlca_ram.sv
// ----------------------------------------------------------------------------
// itlca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itlca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: src/incremental_tree_lca.sv
// ----------------------------------------------------------------------------
// incremental_tree_lca
// Growing rooted tree with binary-lifting lowest common ancestor queries.
// ----------------------------------------------------------------------------
// Usage:
//  - Drive command, node_a, node_b and edge_weight with start high; the
//    transfer takes place at a clock edge where start is high and busy is low.
//  - An add (command 0) attaches a new node under node_a and returns its index,
//    depth and saturated root distance. A query (command 1) returns the lowest
//    common ancestor of node_a and node_b with its depth and distance.
//  - Each result appears for one cycle with done high; the receiver cannot
//    stall, so it must take the result in that cycle.
//  - Rejected commands (full table, unknown node) answer in the cycle after
//    the transfer, with zero payload and a nonzero status.
//  - An add writes the parent entry, then fetches and writes each further
//    ancestor row entry in turn through the single ancestor RAM read port.
//  - A query reads both depths, lifts the deeper node in a first pass, lifts
//    both nodes in a joint pass and ends with the final depth and distance
//    read; the ancestor RAM read port paces both lift passes.
//  - Reset leaves only the root; root entries are never stored but read as
//    zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module incremental_tree_lca (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     command,
	input  logic [itlca_pkg::NODE_W-1:0] node_a,
	input  logic [itlca_pkg::NODE_W-1:0] node_b,
	input  logic [itlca_pkg::WGT_W-1:0]  edge_weight,
	output logic                     done,
	output logic [itlca_pkg::NODE_W-1:0] result_node,
	output logic [itlca_pkg::DEP_W-1:0]  result_depth,
	output logic [itlca_pkg::DIST_W-1:0] result_distance,
	output logic [itlca_pkg::STAT_W-1:0] status
);
	import itlca_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ADD_RD  = 4'd1;
	localparam logic [3:0] S_ADD_ISS = 4'd2;
	localparam logic [3:0] S_ADD_WR  = 4'd3;
	localparam logic [3:0] S_Q_DB    = 4'd4;
	localparam logic [3:0] S_Q_SW    = 4'd5;
	localparam logic [3:0] S_L1      = 4'd6;
	localparam logic [3:0] S_L1_WR   = 4'd7;
	localparam logic [3:0] S_PAR     = 4'd8;
	localparam logic [3:0] S_L2_U    = 4'd9;
	localparam logic [3:0] S_L2_V    = 4'd10;
	localparam logic [3:0] S_L2_C    = 4'd11;
	localparam logic [3:0] S_L2_P    = 4'd12;
	localparam logic [3:0] S_L2_R    = 4'd13;
	localparam logic [3:0] S_FIN_RD  = 4'd14;
	localparam logic [3:0] S_FIN     = 4'd15;

	localparam lvl_t LVL_TOP = lvl_t'(LIFT_LEVELS - 1);

	logic [3:0]       state_q;
	logic [CNT_W-1:0] count_q;
	node_t            u_q, v_q, au_q;
	dep_t             du_q, dv_q, da_q, ndep_q;
	dist_t            ndist_q;
	lvl_t             k_q;
	logic [WGT_W-1:0] w_q;
	logic             anc_rz_q, nd_rz_q;

	// RAM ports
	node_t            anc_rnode, nd_rnode;
	lvl_t             anc_rk;
	logic             anc_we, nd_we;
	lvl_t             anc_wk;
	node_t            anc_wdata;
	node_t            anc_rdata;
	dep_t             dep_rdata;
	dist_t            dist_rdata;
	node_t            anc_x;
	dep_t             dep_x;
	dist_t            dist_x;
	node_t            new_node;

	// Shared arithmetic
	logic [DIST_W:0]  dist_sum;
	dist_t            dist_sat;
	logic [CMP_W-1:0] step;
	logic             can_lift;

	assign new_node = count_q[NODE_W-1:0];
	assign anc_x    = anc_rz_q ? '0 : anc_rdata;
	assign dep_x    = nd_rz_q ? '0 : dep_rdata;
	assign dist_x   = nd_rz_q ? '0 : dist_rdata;
	assign dist_sum = {1'b0, dist_x} + {{(DIST_W + 1 - WGT_W){1'b0}}, w_q};
	assign dist_sat = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
	assign step     = CMP_W'(1) << k_q;
	assign can_lift = {{(CMP_W - DEP_W){1'b0}}, dv_q} >=
		({{(CMP_W - DEP_W){1'b0}}, du_q} + step);
	assign busy     = (state_q != S_IDLE);

	// Read addresses and writes, by state
	always_comb begin
		anc_rnode = '0;
		anc_rk    = '0;
		nd_rnode  = '0;
		anc_we    = 1'b0;
		nd_we     = 1'b0;
		anc_wk    = '0;
		anc_wdata = '0;
		case (state_q)
			S_IDLE:    nd_rnode = node_a;
			S_ADD_RD: begin
				nd_we     = 1'b1;
				anc_we    = 1'b1;
				anc_wdata = u_q;
			end
			S_ADD_ISS: begin
				anc_rnode = u_q;
				anc_rk    = k_q - lvl_t'(1);
			end
			S_ADD_WR: begin
				anc_we    = 1'b1;
				anc_wk    = k_q;
				anc_wdata = anc_x;
			end
			S_Q_DB:    nd_rnode = v_q;
			S_L1: begin
				anc_rnode = v_q;
				anc_rk    = k_q;
			end
			S_L2_U: begin
				anc_rnode = u_q;
				anc_rk    = k_q;
			end
			S_L2_V: begin
				anc_rnode = v_q;
				anc_rk    = k_q;
			end
			S_L2_P:    anc_rnode = u_q;
			S_FIN_RD:  nd_rnode = u_q;
			default: begin
			end
		endcase
	end

	itlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES << LVL_W)) u_anc_ram (
		.clk   (clk),
		.we    (anc_we),
		.waddr ({new_node, anc_wk}),
		.wdata (anc_wdata),
		.raddr ({anc_rnode, anc_rk}),
		.rdata (anc_rdata)
	);

	itlca_ram #(.WIDTH(DEP_W), .DEPTH(MAX_NODES)) u_dep_ram (
		.clk   (clk),
		.we    (nd_we),
		.waddr (new_node),
		.wdata (dep_x + dep_t'(1)),
		.raddr (nd_rnode),
		.rdata (dep_rdata)
	);

	itlca_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
		.clk   (clk),
		.we    (nd_we),
		.waddr (new_node),
		.wdata (dist_sat),
		.raddr (nd_rnode),
		.rdata (dist_rdata)
	);

	// Root rows are never stored: mark reads of node 0 so they return zero
	always_ff @(posedge clk) begin
		anc_rz_q <= (anc_rnode == '0);
		nd_rz_q  <= (nd_rnode == '0);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CNT_W'(1);
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						u_q <= node_a;
						v_q <= node_b;
						w_q <= edge_weight;
						if (command == CMD_ADD) begin
							if (count_q >= CNT_W'(MAX_NODES)) begin
								done <= 1'b1;
								status <= ST_FULL;
							end else if ({1'b0, node_a} >= count_q) begin
								done <= 1'b1;
								status <= ST_UNKNOWN;
							end else begin
								state_q <= S_ADD_RD;
							end
						end else begin
							if (({1'b0, node_a} >= count_q) ||
							    ({1'b0, node_b} >= count_q)) begin
								done <= 1'b1;
								status <= ST_UNKNOWN;
							end else begin
								state_q <= S_Q_DB;
							end
						end
					end
				end
				S_ADD_RD: begin
					ndep_q  <= dep_x + dep_t'(1);
					ndist_q <= dist_sat;
					k_q     <= lvl_t'(1);
					if (LIFT_LEVELS == 1) begin
						done    <= 1'b1;
						status  <= ST_OK;
						count_q <= count_q + CNT_W'(1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ADD_ISS;
					end
				end
				S_ADD_ISS: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					u_q <= anc_x;
					if (k_q == LVL_TOP) begin
						done    <= 1'b1;
						status  <= ST_OK;
						count_q <= count_q + CNT_W'(1);
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + lvl_t'(1);
						state_q <= S_ADD_ISS;
					end
				end
				S_Q_DB: begin
					da_q    <= dep_x;
					state_q <= S_Q_SW;
				end
				S_Q_SW: begin
					// keep u as the shallower node
					if (da_q > dep_x) begin
						u_q  <= v_q;
						v_q  <= u_q;
						du_q <= dep_x;
						dv_q <= da_q;
					end else begin
						du_q <= da_q;
						dv_q <= dep_x;
					end
					k_q     <= LVL_TOP;
					state_q <= S_L1;
				end
				S_L1: begin
					if (can_lift) begin
						state_q <= S_L1_WR;
					end else if (k_q == '0) begin
						state_q <= S_PAR;
					end else begin
						k_q <= k_q - lvl_t'(1);
					end
				end
				S_L1_WR: begin
					v_q  <= anc_x;
					dv_q <= dv_q - step[DEP_W-1:0];
					if (k_q == '0) begin
						state_q <= S_PAR;
					end else begin
						k_q     <= k_q - lvl_t'(1);
						state_q <= S_L1;
					end
				end
				S_PAR: begin
					k_q     <= LVL_TOP;
					state_q <= (u_q == v_q) ? S_FIN_RD : S_L2_U;
				end
				S_L2_U: state_q <= S_L2_V;
				S_L2_V: begin
					au_q    <= anc_x;
					state_q <= S_L2_C;
				end
				S_L2_C: begin
					if (au_q != anc_x) begin
						u_q <= au_q;
						v_q <= anc_x;
					end
					if (k_q == '0) begin
						state_q <= S_L2_P;
					end else begin
						k_q     <= k_q - lvl_t'(1);
						state_q <= S_L2_U;
					end
				end
				S_L2_P: state_q <= S_L2_R;
				S_L2_R: begin
					u_q     <= anc_x;
					state_q <= S_FIN_RD;
				end
				S_FIN_RD: state_q <= S_FIN;
				S_FIN: begin
					ndep_q  <= dep_x;
					ndist_q <= dist_x;
					done    <= 1'b1;
					status  <= ST_OK;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload: add returns the new index, query the ancestor
	logic last_add_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_add_q <= 1'b0;
		end else if (state_q == S_IDLE && start) begin
			last_add_q <= (command == CMD_ADD);
		end
	end

	node_t res_node_q;
	always_ff @(posedge clk) begin
		if (state_q == S_ADD_RD) begin
			res_node_q <= new_node;
		end else if (state_q == S_FIN) begin
			res_node_q <= u_q;
		end
	end

	logic is_ok;
	assign is_ok           = (status == ST_OK);
	assign result_node     = is_ok ? (last_add_q ? res_node_q : u_q) : '0;
	assign result_depth    = is_ok ? (last_add_q ? ndep_q : ndep_q) : '0;
	assign result_distance = is_ok ? ndist_q : '0;

	// A result only appears once the block has returned to idle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	// The node count stays within the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(1)) && (count_q <= CNT_W'(MAX_NODES)))
		else $error("node count out of range");
	// A successful add grows the tree by exactly one node
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_ok && last_add_q) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("add did not advance node count");
	// A rejected command leaves the node count untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_ok) |-> $stable(count_q))
		else $error("rejected command changed node count");
endmodule
